FILE: design/midpoint_circle_rasterizer_assert.svh
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer assertion macros
// Shared concurrent assertion forms used by the rasterizer modules.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_CIRCLE_RASTERIZER_ASSERT_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MCR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("midpoint circle rasterizer: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define MCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("midpoint circle rasterizer: next-cycle check failed");

`endif

FILE: design/mcr_pkg.sv
// ----------------------------------------------------------------------------
// mcr_pkg
// Widths, constants and the job record shared by the circle rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package mcr_pkg;

  // Field widths.
  localparam int COORD_BITS  = 12;
  localparam int RADIUS_BITS = 10;
  localparam int DEC_BITS    = RADIUS_BITS + 4;
  localparam int OUT_BITS    = COORD_BITS + 1;
  localparam int SUM_BITS    = RADIUS_BITS + 6;

  // Job queue depth; must be a power of two.
  localparam int JOBQ_DEPTH  = 2;
  localparam int JOBQ_AW     = $clog2(JOBQ_DEPTH);

  // Number of symmetric points per circle position.
  localparam int NUM_POINTS  = 8;
  localparam int IDX_BITS    = $clog2(NUM_POINTS);
  localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(NUM_POINTS - 1);

  // Request modes.
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  // Decision update constants of the midpoint rule.
  localparam logic signed [DEC_BITS-1:0] DEC_INIT = DEC_BITS'(3);
  localparam logic signed [SUM_BITS-1:0] INC_LT   = SUM_BITS'(6);
  localparam logic signed [SUM_BITS-1:0] INC_GE   = SUM_BITS'(10);

  // One unit of work handed from the front to the back.
  typedef struct packed {
    logic                          done;
    logic signed [COORD_BITS-1:0]  cx;
    logic signed [COORD_BITS-1:0]  cy;
    logic        [RADIUS_BITS-1:0] x;
    logic        [RADIUS_BITS-1:0] y;
  } job_t;

endpackage

`default_nettype wire

FILE: design/mcr_front.sv
// ----------------------------------------------------------------------------
// mcr_front
// Accepts requests, keeps the circle state and advances the midpoint
// decision, producing one job per request.
// ----------------------------------------------------------------------------
`default_nettype none
`include "midpoint_circle_rasterizer_assert.svh"

module mcr_front (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  accept,
  input  wire logic                                  mode,
  input  wire logic signed [mcr_pkg::COORD_BITS-1:0] center_x,
  input  wire logic signed [mcr_pkg::COORD_BITS-1:0] center_y,
  input  wire logic        [mcr_pkg::RADIUS_BITS-1:0] radius,
  output mcr_pkg::job_t                              job
);

  logic                                  active_r, active_nxt;
  logic signed [mcr_pkg::COORD_BITS-1:0] cx_r, cx_nxt;
  logic signed [mcr_pkg::COORD_BITS-1:0] cy_r, cy_nxt;
  logic        [mcr_pkg::RADIUS_BITS-1:0] x_r, x_nxt;
  logic        [mcr_pkg::RADIUS_BITS-1:0] y_r, y_nxt;
  logic signed [mcr_pkg::DEC_BITS-1:0]    p_r, p_nxt;

  logic signed [mcr_pkg::SUM_BITS-1:0] xs, ys, ps, p_sum;
  logic                                step_done;

  // Widened operands for the decision update.
  assign xs = $signed({{(mcr_pkg::SUM_BITS-mcr_pkg::RADIUS_BITS){1'b0}}, x_r});
  assign ys = $signed({{(mcr_pkg::SUM_BITS-mcr_pkg::RADIUS_BITS){1'b0}}, y_r});
  assign ps = mcr_pkg::SUM_BITS'(p_r);

  // A step with no circle, or one that has reached the diagonal, is done.
  assign step_done = !active_r || (x_r >= y_r);

  // Midpoint decision rule.
  always_comb begin
    if (p_r < 0) begin
      p_sum = ps + (xs <<< 2) + mcr_pkg::INC_LT;
    end else begin
      p_sum = ps + ((xs - ys) <<< 2) + mcr_pkg::INC_GE;
    end
  end

  // Next circle state.
  always_comb begin
    active_nxt = active_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    p_nxt      = p_r;
    if (accept) begin
      if (mode == mcr_pkg::MODE_START) begin
        active_nxt = 1'b1;
        cx_nxt     = center_x;
        cy_nxt     = center_y;
        x_nxt      = '0;
        y_nxt      = radius;
        p_nxt      = mcr_pkg::DEC_INIT -
                     mcr_pkg::DEC_BITS'({radius, 1'b0});
      end else if (step_done) begin
        active_nxt = 1'b0;
      end else begin
        x_nxt = x_r + 1'b1;
        p_nxt = p_sum[mcr_pkg::DEC_BITS-1:0];
        if (p_r >= 0) begin
          y_nxt = y_r - 1'b1;
        end
      end
    end
  end

  // The job reflects the state after this request.
  always_comb begin
    job.done = (mode == mcr_pkg::MODE_STEP) && step_done;
    job.cx   = cx_nxt;
    job.cy   = cy_nxt;
    job.x    = x_nxt;
    job.y    = y_nxt;
  end

  // Circle state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cx_r     <= '0;
      cy_r     <= '0;
      x_r      <= '0;
      y_r      <= '0;
      p_r      <= '0;
    end else begin
      active_r <= active_nxt;
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      p_r      <= p_nxt;
    end
  end

  // A start always leaves an active circle at the top of the arc.
  `MCR_ASSERT_NEXT(a_start_loads, clk, rst_n,
    accept && (mode == mcr_pkg::MODE_START), active_r && (x_r == '0))
  // A finished step always drops the circle.
  `MCR_ASSERT_NEXT(a_done_clears, clk, rst_n, accept && job.done, !active_r)

endmodule

`default_nettype wire

FILE: design/mcr_jobq.sv
// ----------------------------------------------------------------------------
// mcr_jobq
// Short queue of jobs between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "midpoint_circle_rasterizer_assert.svh"

module mcr_jobq (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  wire mcr_pkg::job_t wr_job,
  output logic      full,
  input  wire logic rd_en,
  output logic      head_valid,
  output mcr_pkg::job_t head_job
);

  mcr_pkg::job_t                   mem_r [mcr_pkg::JOBQ_DEPTH];
  logic [mcr_pkg::JOBQ_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [mcr_pkg::JOBQ_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [mcr_pkg::JOBQ_AW:0]       count_r, count_nxt;

  assign full       = (count_r == (mcr_pkg::JOBQ_AW+1)'(mcr_pkg::JOBQ_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];

  // Pointer and count updates.
  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  // Occupancy never runs past the depth and pointers agree with it.
  `MCR_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1,
    count_r <= (mcr_pkg::JOBQ_AW+1)'(mcr_pkg::JOBQ_DEPTH))
  `MCR_ASSERT_NOW(a_ptr_agree, clk, rst_n, 1'b1,
    (wr_ptr_r - rd_ptr_r) == count_r[mcr_pkg::JOBQ_AW-1:0])

endmodule

`default_nettype wire

FILE: design/mcr_back.sv
// ----------------------------------------------------------------------------
// mcr_back
// Expands each job into its eight symmetric pixels, or one done result,
// and holds the oldest result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "midpoint_circle_rasterizer_assert.svh"

module mcr_back (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic job_valid,
  input  wire mcr_pkg::job_t job,
  output logic      job_pop,
  output logic      empty,
  input  wire logic pop,
  output logic signed [mcr_pkg::OUT_BITS-1:0] point_x,
  output logic signed [mcr_pkg::OUT_BITS-1:0] point_y,
  output logic      done_res,
  output logic      last
);

  logic [mcr_pkg::IDX_BITS-1:0] idx_r, idx_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic signed [mcr_pkg::OUT_BITS-1:0] px_r, py_r;
  logic                         done_r, last_r;

  logic                         emit, swap, neg_x, neg_y, emit_last;
  logic signed [mcr_pkg::OUT_BITS-1:0] cx_w, cy_w, offx, offy, px_w, py_w;

  // Point order: the first four use (x, y), the last four use (y, x).
  assign swap  = idx_r[2];
  assign neg_x = swap ? idx_r[1] : idx_r[0];
  assign neg_y = swap ? idx_r[0] : idx_r[1];

  assign cx_w = mcr_pkg::OUT_BITS'(job.cx);
  assign cy_w = mcr_pkg::OUT_BITS'(job.cy);
  assign offx = $signed(mcr_pkg::OUT_BITS'(swap ? job.y : job.x));
  assign offy = $signed(mcr_pkg::OUT_BITS'(swap ? job.x : job.y));

  // Pixel coordinates, or zero for a done result.
  always_comb begin
    if (job.done) begin
      px_w = '0;
      py_w = '0;
    end else begin
      px_w = neg_x ? cx_w - offx : cx_w + offx;
      py_w = neg_y ? cy_w - offy : cy_w + offy;
    end
  end

  // Emit when a job waits and the output register is free or draining.
  assign emit      = job_valid && (!out_valid_r || pop);
  assign emit_last = job.done || (idx_r == mcr_pkg::IDX_LAST);
  assign job_pop   = emit && emit_last;

  always_comb begin
    idx_nxt = idx_r;
    if (emit) begin
      idx_nxt = emit_last ? '0 : idx_r + 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (emit) begin
      px_r   <= px_w;
      py_r   <= py_w;
      done_r <= job.done;
      last_r <= emit_last;
    end
  end

  assign empty    = !out_valid_r;
  assign point_x  = px_r;
  assign point_y  = py_r;
  assign done_res = done_r;
  assign last     = last_r;

  // Mid-expansion means the job is still at the queue head.
  `MCR_ASSERT_NOW(a_mid_job, clk, rst_n, idx_r != '0, job_valid && !job.done)
  // A done result is never emitted in the middle of a pixel run.
  `MCR_ASSERT_NOW(a_done_at_start, clk, rst_n, emit && job.done, idx_r == '0)

endmodule

`default_nettype wire

FILE: design/midpoint_circle_rasterizer.sv
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer
// Midpoint circle rasterizer with eight-way symmetry and queue-style ports.
// ----------------------------------------------------------------------------
// A start request (mode 0) loads a center and radius and yields the eight
// symmetric pixels of the top of the arc; each step request (mode 1) advances
// the midpoint decision once and yields the next eight pixels, last marking
// the eighth. A step with no circle, or on or past the diagonal, yields one
// result with done_res set. The front accepts one request per cycle while
// its two-entry job queue has room; the back emits one result per cycle while
// its output register is free or being popped, so a pixel request yields eight
// results and a done request one. Results wait in an output register, so
// while pop is low requests are still taken only until that register and the
// job queue fill.
// ----------------------------------------------------------------------------
`default_nettype none

module midpoint_circle_rasterizer (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   push,
  output logic                                        full,
  input  wire logic                                   in_mode,
  input  wire logic signed [mcr_pkg::COORD_BITS-1:0]  in_center_x,
  input  wire logic signed [mcr_pkg::COORD_BITS-1:0]  in_center_y,
  input  wire logic        [mcr_pkg::RADIUS_BITS-1:0] in_radius,
  output logic                                        empty,
  input  wire logic                                   pop,
  output logic signed [mcr_pkg::OUT_BITS-1:0]         out_point_x,
  output logic signed [mcr_pkg::OUT_BITS-1:0]         out_point_y,
  output logic                                        out_done_res,
  output logic                                        out_last
);

  logic          accept;
  logic          job_pop;
  logic          head_valid;
  mcr_pkg::job_t new_job;
  mcr_pkg::job_t head_job;

  // A request is taken whenever the job queue has room.
  assign accept = push && !full;

  mcr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .mode     (in_mode),
    .center_x (in_center_x),
    .center_y (in_center_y),
    .radius   (in_radius),
    .job      (new_job)
  );

  mcr_jobq u_jobq (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (accept),
    .wr_job     (new_job),
    .full       (full),
    .rd_en      (job_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  mcr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (head_valid),
    .job       (head_job),
    .job_pop   (job_pop),
    .empty     (empty),
    .pop       (pop),
    .point_x   (out_point_x),
    .point_y   (out_point_y),
    .done_res  (out_done_res),
    .last      (out_last)
  );

endmodule

`default_nettype wire

FILE: test/tb_midpoint_circle_rasterizer.sv
// ----------------------------------------------------------------------------
// tb_midpoint_circle_rasterizer
// Drives start and step requests into the circle rasterizer and checks every
// pixel and done result in order against a midpoint-rule predictor. Both
// sides of the queue ports idle in random bursts, except near the end.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_midpoint_circle_rasterizer;
  timeunit 1ns;
  timeprecision 1ps;

  import mcr_pkg::COORD_BITS;
  import mcr_pkg::RADIUS_BITS;
  import mcr_pkg::DEC_BITS;
  import mcr_pkg::OUT_BITS;
  import mcr_pkg::MODE_START;
  import mcr_pkg::MODE_STEP;

  // Requests left in the queue when random idling stops.
  localparam int CALM_ITEMS   = 30;
  // Cycles without any transfer before the run is abandoned.
  localparam int STALL_LIMIT  = 2000;
  // Cycles to wait after the last expected result.
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic                          mode;
    logic signed [COORD_BITS-1:0]  cx;
    logic signed [COORD_BITS-1:0]  cy;
    logic        [RADIUS_BITS-1:0] r;
  } circle_req_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] x;
    logic signed [OUT_BITS-1:0] y;
    logic                       done;
    logic                       last;
  } pixel_t;

  // Clock, reset and block ports.
  logic                           clk         = 1'b0;
  logic                           rst_n       = 1'b0;
  logic                           push        = 1'b0;
  logic                           full;
  logic                           in_mode     = 1'b0;
  logic signed [COORD_BITS-1:0]   in_center_x = '0;
  logic signed [COORD_BITS-1:0]   in_center_y = '0;
  logic        [RADIUS_BITS-1:0]  in_radius   = '0;
  logic                           empty;
  logic                           pop         = 1'b0;
  logic signed [OUT_BITS-1:0]     out_point_x;
  logic signed [OUT_BITS-1:0]     out_point_y;
  logic                           out_done_res;
  logic                           out_last;

  // Requests waiting to be driven and pixels the block still owes.
  circle_req_t req_q[$];
  pixel_t      pixel_q[$];

  // Predicted circle state.
  logic                          circle_on = 1'b0;
  logic signed [COORD_BITS-1:0]  ctr_x     = '0;
  logic signed [COORD_BITS-1:0]  ctr_y     = '0;
  logic        [RADIUS_BITS-1:0] x_off     = '0;
  logic        [RADIUS_BITS-1:0] y_off     = '0;
  logic signed [DEC_BITS-1:0]    dec       = '0;

  int     errors     = 0;
  int     src_gap    = 0;
  int     snk_gap    = 0;
  int     quiet_cnt  = 0;
  pixel_t got_px;
  pixel_t want_px;

  always #5 clk = ~clk;

  midpoint_circle_rasterizer i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_mode      (in_mode),
    .in_center_x  (in_center_x),
    .in_center_y  (in_center_y),
    .in_radius    (in_radius),
    .empty        (empty),
    .pop          (pop),
    .out_point_x  (out_point_x),
    .out_point_y  (out_point_y),
    .out_done_res (out_done_res),
    .out_last     (out_last)
  );

  // Queue one request, keeping only the port widths of each field.
  function automatic void add_req(logic mode, int cx, int cy, int r);
    circle_req_t req;
    req.mode = mode;
    req.cx   = COORD_BITS'(cx);
    req.cy   = COORD_BITS'(cy);
    req.r    = RADIUS_BITS'(r);
    req_q.push_back(req);
  endfunction

  function automatic void put_pixel(int px, int py, logic last);
    pixel_t p;
    p.x    = OUT_BITS'(px);
    p.y    = OUT_BITS'(py);
    p.done = 1'b0;
    p.last = last;
    pixel_q.push_back(p);
  endfunction

  // The eight symmetric points of the current offset, in output order.
  function automatic void plot_octants();
    int cx, cy, x, y;
    cx = ctr_x;
    cy = ctr_y;
    x  = x_off;
    y  = y_off;
    put_pixel(cx + x, cy + y, 1'b0);
    put_pixel(cx - x, cy + y, 1'b0);
    put_pixel(cx + x, cy - y, 1'b0);
    put_pixel(cx - x, cy - y, 1'b0);
    put_pixel(cx + y, cy + x, 1'b0);
    put_pixel(cx + y, cy - x, 1'b0);
    put_pixel(cx - y, cy + x, 1'b0);
    put_pixel(cx - y, cy - x, 1'b1);
  endfunction

  // Advance the predicted circle by one request and queue what it yields.
  function automatic void rasterize(circle_req_t req);
    int     p;
    pixel_t fin;
    if (req.mode == MODE_START) begin
      ctr_x     = req.cx;
      ctr_y     = req.cy;
      x_off     = '0;
      y_off     = req.r;
      dec       = DEC_BITS'(3 - 2 * int'(req.r));
      circle_on = 1'b1;
      plot_octants();
    end else if (!circle_on || x_off >= y_off) begin
      // Nothing to draw: one done marker, and the circle is closed.
      circle_on = 1'b0;
      fin       = '0;
      fin.done  = 1'b1;
      fin.last  = 1'b1;
      pixel_q.push_back(fin);
    end else begin
      if (dec < 0) begin
        p = int'(dec) + 4 * int'(x_off) + 6;
      end else begin
        p     = int'(dec) + 4 * (int'(x_off) - int'(y_off)) + 10;
        y_off = y_off - 1'b1;
      end
      x_off = x_off + 1'b1;
      dec   = DEC_BITS'(p);
      plot_octants();
    end
  endfunction

  // Driver: presents the oldest pending request and retires it on transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        rasterize(req_q.pop_front());
      end
      // A request that was not taken stays on the ports unchanged.
      if (!push || !full) begin
        if (src_gap != 0) begin
          src_gap <= src_gap - 1;
          push    <= 1'b0;
        end else if (req_q.size() > CALM_ITEMS && $urandom_range(0, 5) == 0) begin
          src_gap <= $urandom_range(0, 7);
          push    <= 1'b0;
        end else if (req_q.size() != 0) begin
          push        <= 1'b1;
          in_mode     <= req_q[0].mode;
          in_center_x <= req_q[0].cx;
          in_center_y <= req_q[0].cy;
          in_radius   <= req_q[0].r;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: takes results with random stalls and checks each in order.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        got_px.x    = out_point_x;
        got_px.y    = out_point_y;
        got_px.done = out_done_res;
        got_px.last = out_last;
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected result x=%0d y=%0d done=%0b last=%0b", $time,
                   got_px.x, got_px.y, got_px.done, got_px.last);
          errors++;
        end else begin
          want_px = pixel_q.pop_front();
          if (got_px != want_px) begin
            $display({"%0t: mismatch, expected x=%0d y=%0d done=%0b last=%0b,",
                      " got x=%0d y=%0d done=%0b last=%0b"},
                     $time, want_px.x, want_px.y, want_px.done, want_px.last,
                     got_px.x, got_px.y, got_px.done, got_px.last);
            errors++;
          end
        end
      end
      if (snk_gap != 0) begin
        snk_gap <= snk_gap - 1;
        pop     <= 1'b0;
      end else if (req_q.size() > CALM_ITEMS && $urandom_range(0, 4) == 0) begin
        snk_gap <= $urandom_range(0, 7);
        pop     <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: a long stretch with no transfer on either side ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) begin
        quiet_cnt <= 0;
      end else if (quiet_cnt >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        quiet_cnt <= quiet_cnt + 1;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int pick, r, n;

    // Directed: step before any circle, zero radius, extremes, restart.
    add_req(MODE_STEP, 0, 0, 0);
    add_req(MODE_START, 0, 0, 0);
    add_req(MODE_STEP, 0, 0, 0);
    add_req(MODE_STEP, 0, 0, 0);
    add_req(MODE_START, 2047, 2047, 1023);
    repeat (3) add_req(MODE_STEP, 0, 0, 0);
    add_req(MODE_START, -2048, -2048, 1023);
    repeat (2) add_req(MODE_STEP, 0, 0, 0);
    // A new start while the old circle is still active.
    add_req(MODE_START, 2047, -2048, 5);
    repeat (6) add_req(MODE_STEP, 0, 0, 0);
    add_req(MODE_START, -2048, 2047, 1);
    repeat (2) add_req(MODE_STEP, 0, 0, 0);
    add_req(MODE_START, 'h555, 'haaa, 'h2aa);
    add_req(MODE_STEP, 'haaa, 'h555, 'h155);

    // Random: mostly whole or partial circles, some lone requests.
    while (req_q.size() < 210) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 24);
        add_req(MODE_START, $urandom, $urandom, r);
        if (r > 24) begin
          n = $urandom_range(0, 12);
        end else if ($urandom_range(0, 9) < 7) begin
          n = r * 3 / 4 + 2;
        end else begin
          n = $urandom_range(0, r * 3 / 4);
        end
        repeat (n) add_req(MODE_STEP, $urandom, $urandom, $urandom);
      end else if (pick < 90) begin
        add_req(MODE_STEP, $urandom, $urandom, $urandom);
      end else begin
        add_req(MODE_START, $urandom, $urandom, $urandom);
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (req_q.size() != 0 || pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
